/* sv/tcr_pkg.sv */
// Shared constants, codes and types of the transport connection receiver.
`default_nettype none

package tcr_pkg;

   // table size and buffer depth
   localparam int SLOTS     = 4;
   localparam int BUF_BYTES = 65536;
   localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EXT_W     = 5;

   // field widths
   localparam int OP_W    = 3;
   localparam int SLOT_W  = 2;
   localparam int PORT_W  = 16;
   localparam int TYPE_W  = 3;
   localparam int SEQ_W   = 32;
   localparam int LEN_W   = 16;
   localparam int BYTES_W = 17;
   localparam int TICK_W  = 16;
   localparam int CST_W   = 2;

   typedef logic [OP_W-1:0]   opcode_type;
   typedef logic [TYPE_W-1:0] seg_kind_type;
   typedef logic [CST_W-1:0]  conn_state_type;

   // operations
   localparam opcode_type OP_OPEN    = 3'd0;
   localparam opcode_type OP_LISTEN  = 3'd1;
   localparam opcode_type OP_SEGMENT = 3'd2;
   localparam opcode_type OP_TICK    = 3'd3;
   localparam opcode_type OP_CONSUME = 3'd4;
   localparam opcode_type OP_CLOSE   = 3'd5;

   // segment kinds
   localparam seg_kind_type T_SYN     = 3'd0;
   localparam seg_kind_type T_SYNACK  = 3'd1;
   localparam seg_kind_type T_FIN     = 3'd2;
   localparam seg_kind_type T_FINACK  = 3'd3;
   localparam seg_kind_type T_DATA    = 3'd4;
   localparam seg_kind_type T_DATAACK = 3'd5;
   localparam seg_kind_type T_NONE    = 3'd0;

   // connection states
   localparam conn_state_type ST_CLOSED    = 2'd0;
   localparam conn_state_type ST_LISTENING = 2'd1;
   localparam conn_state_type ST_CONNECTED = 2'd2;
   localparam conn_state_type ST_CLOSEWAIT = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic match;
      logic exec;
   } tcr_cmd_type;

endpackage

`default_nettype wire

/* sv/transport_connection_receiver.sv */
// Top level of the transport connection receiver: controller, datapath and checks.
//
// Usage:
//   Request channel: drive the req_ fields with start high; the transaction is
//   taken at a rising edge with start high and busy low. busy stays high until
//   the result has been presented.
//   Result channel: rsp_strobe is high for exactly one cycle with all rsp_
//   fields valid. The receiver cannot stall; the result is taken at that edge.
//   Every transaction gives exactly one result.
//   Sequence: after the accept edge the controller steps through the table
//   search (MATCH), update (EXEC) and result (RESP) states, and the result
//   strobe is high in RESP. busy drops with the strobe, so a new transaction
//   is taken only after the result has been presented. The table search across
//   all slots and the update are registered in turn in the datapath.
//   Configuration: csr_data is the close-wait length in ticks, written at an
//   edge with csr_valid and csr_ready high; csr_ready is always high. Write it
//   only while busy is low.
//   Reset (synchronous, active high): all slots free and closed, counters
//   clear, close-wait length 1, controller idle.
`default_nettype none

module transport_connection_receiver (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [tcr_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [tcr_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_open_port,
   input  wire logic [tcr_pkg::TYPE_W-1:0]     req_seg_type,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_seg_src_port,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_seg_dest_port,
   input  wire logic [tcr_pkg::SEQ_W-1:0]      req_seg_seq,
   input  wire logic [tcr_pkg::LEN_W-1:0]      req_seg_length,
   input  wire logic [tcr_pkg::BYTES_W-1:0]    req_consume_length,
   output logic                                rsp_strobe,
   output logic                                rsp_reply_valid,
   output logic [tcr_pkg::TYPE_W-1:0]          rsp_reply_type,
   output logic [tcr_pkg::PORT_W-1:0]          rsp_reply_src_port,
   output logic [tcr_pkg::PORT_W-1:0]          rsp_reply_dest_port,
   output logic [tcr_pkg::SEQ_W-1:0]           rsp_reply_seq,
   output logic [tcr_pkg::SEQ_W-1:0]           rsp_reply_ack,
   output logic                                rsp_status,
   output logic [tcr_pkg::SLOT_W-1:0]          rsp_result_slot,
   output logic [tcr_pkg::CST_W-1:0]           rsp_slot_state,
   output logic [tcr_pkg::BYTES_W-1:0]         rsp_slot_used_bytes,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tcr_pkg::TICK_W-1:0]     csr_data
);
   import tcr_pkg::*;

   tcr_cmd_type cmd;

   // accept register writes at any time
   assign csr_ready = 1'b1;

   tcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   tcr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_wr              (csr_valid && csr_ready),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_slot            (req_slot),
      .req_open_port       (req_open_port),
      .req_seg_type        (req_seg_type),
      .req_seg_src_port    (req_seg_src_port),
      .req_seg_dest_port   (req_seg_dest_port),
      .req_seg_seq         (req_seg_seq),
      .req_seg_length      (req_seg_length),
      .req_consume_length  (req_consume_length),
      .rsp_reply_valid     (rsp_reply_valid),
      .rsp_reply_type      (rsp_reply_type),
      .rsp_reply_src_port  (rsp_reply_src_port),
      .rsp_reply_dest_port (rsp_reply_dest_port),
      .rsp_reply_seq       (rsp_reply_seq),
      .rsp_reply_ack       (rsp_reply_ack),
      .rsp_status          (rsp_status),
      .rsp_result_slot     (rsp_result_slot),
      .rsp_slot_state      (rsp_slot_state),
      .rsp_slot_used_bytes (rsp_slot_used_bytes)
   );

   // the result strobe follows each rise of busy, after the search and update states
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ##2 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // the strobe marks a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // a reply segment only comes with a successful transaction
   a_reply_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_reply_valid) |-> (rsp_status == 1'b0))
      else $error("reply segment sent with failure status");

endmodule

`default_nettype wire

/* sv/tcr_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none

module tcr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_strobe,
   output tcr_pkg::tcr_cmd_type      cmd
);
   import tcr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_EXEC  = 4'b0100,
      S_RESP  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // advance one step per cycle once a transaction is taken
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_MATCH;
         S_MATCH: state_in = S_EXEC;
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // drive commands and handshake
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);
   assign cmd.load   = start && (state_ff == S_IDLE);
   assign cmd.match  = (state_ff == S_MATCH);
   assign cmd.exec   = (state_ff == S_EXEC);

endmodule

`default_nettype wire

/* sv/tcr_datapath.sv */
// Datapath: slot table, port search, per-operation update and result registers.
`default_nettype none

module tcr_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tcr_pkg::tcr_cmd_type           cmd,
   input  wire logic                           csr_wr,
   input  wire logic [tcr_pkg::TICK_W-1:0]     csr_data,
   input  wire logic [tcr_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [tcr_pkg::SLOT_W-1:0]     req_slot,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_open_port,
   input  wire logic [tcr_pkg::TYPE_W-1:0]     req_seg_type,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_seg_src_port,
   input  wire logic [tcr_pkg::PORT_W-1:0]     req_seg_dest_port,
   input  wire logic [tcr_pkg::SEQ_W-1:0]      req_seg_seq,
   input  wire logic [tcr_pkg::LEN_W-1:0]      req_seg_length,
   input  wire logic [tcr_pkg::BYTES_W-1:0]    req_consume_length,
   output logic                                rsp_reply_valid,
   output logic [tcr_pkg::TYPE_W-1:0]          rsp_reply_type,
   output logic [tcr_pkg::PORT_W-1:0]          rsp_reply_src_port,
   output logic [tcr_pkg::PORT_W-1:0]          rsp_reply_dest_port,
   output logic [tcr_pkg::SEQ_W-1:0]           rsp_reply_seq,
   output logic [tcr_pkg::SEQ_W-1:0]           rsp_reply_ack,
   output logic                                rsp_status,
   output logic [tcr_pkg::SLOT_W-1:0]          rsp_result_slot,
   output logic [tcr_pkg::CST_W-1:0]           rsp_slot_state,
   output logic [tcr_pkg::BYTES_W-1:0]         rsp_slot_used_bytes
);
   import tcr_pkg::*;

   // configuration
   logic [TICK_W-1:0] cw_ticks_ff;

   // captured transaction
   opcode_type        op_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [PORT_W-1:0] open_port_ff;
   seg_kind_type      seg_type_ff;
   logic [PORT_W-1:0] src_port_ff;
   logic [PORT_W-1:0] dest_port_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [BYTES_W-1:0] clen_ff;

   // slot table
   logic                 in_use_ff      [SLOTS];
   logic [PORT_W-1:0]    server_port_ff [SLOTS];
   logic [PORT_W-1:0]    client_port_ff [SLOTS];
   conn_state_type       state_ff       [SLOTS];
   logic [SEQ_W-1:0]     exp_seq_ff     [SLOTS];
   logic [BYTES_W-1:0]   used_ff        [SLOTS];
   logic [TICK_W-1:0]    cwl_ff         [SLOTS];

   logic                 in_use_in      [SLOTS];
   logic [PORT_W-1:0]    server_port_in [SLOTS];
   logic [PORT_W-1:0]    client_port_in [SLOTS];
   conn_state_type       state_in       [SLOTS];
   logic [SEQ_W-1:0]     exp_seq_in     [SLOTS];
   logic [BYTES_W-1:0]   used_in        [SLOTS];
   logic [TICK_W-1:0]    cwl_in         [SLOTS];

   // search results
   logic              tgt_ok_ff;
   logic [SIDX_W-1:0] tgt_idx_ff;
   logic [SLOT_W-1:0] rs_ff;
   logic              tgt_ok_in;
   logic [SIDX_W-1:0] tgt_idx_in;
   logic [SLOT_W-1:0] rs_in;

   // result registers
   logic               reply_valid_ff;
   seg_kind_type       reply_type_ff;
   logic [PORT_W-1:0]  reply_src_ff;
   logic [PORT_W-1:0]  reply_dest_ff;
   logic [SEQ_W-1:0]   reply_seq_ff;
   logic [SEQ_W-1:0]   reply_ack_ff;
   logic               status_ff;
   logic [SLOT_W-1:0]  result_slot_ff;
   conn_state_type     slot_state_ff;
   logic [BYTES_W-1:0] slot_used_ff;

   // update stage signals
   logic               stat_in;
   logic               have;
   logic               rv;
   seg_kind_type       rtype;
   conn_state_type     st_cur;
   logic [BYTES_W-1:0] used_cur;
   logic [SEQ_W-1:0]   exp_cur;
   logic [BYTES_W:0]   sum;

   // hold the close-wait length register
   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ticks_ff <= TICK_W'(1);
      end else if (csr_wr) begin
         cw_ticks_ff <= csr_data;
      end
   end

   // capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_opcode;
         slot_ff      <= req_slot;
         open_port_ff <= req_open_port;
         seg_type_ff  <= req_seg_type;
         src_port_ff  <= req_seg_src_port;
         dest_port_ff <= req_seg_dest_port;
         seq_ff       <= req_seg_seq;
         len_ff       <= req_seg_length;
         clen_ff      <= req_consume_length;
      end
   end

   // search the table: duplicate port, free slot, segment match, addressed slot
   always_comb begin
      logic              dup;
      logic              free_found;
      logic [SIDX_W-1:0] free_idx;
      logic              seg_found;
      logic [SIDX_W-1:0] seg_idx;
      logic              usable;
      logic [SIDX_W-1:0] sl_idx;
      dup        = 1'b0;
      free_found = 1'b0;
      free_idx   = '0;
      seg_found  = 1'b0;
      seg_idx    = '0;
      sl_idx     = SIDX_W'(slot_ff);
      usable     = (EXT_W'(slot_ff) < EXT_W'(SLOTS)) && in_use_ff[sl_idx];
      for (int i = 0; i < SLOTS; i++) begin
         if (in_use_ff[i] && server_port_ff[i] == open_port_ff) dup = 1'b1;
         if (!free_found && !in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SIDX_W'(i);
         end
         if (!seg_found && in_use_ff[i] && server_port_ff[i] == dest_port_ff &&
             (seg_type_ff == T_SYN || client_port_ff[i] == src_port_ff)) begin
            seg_found = 1'b1;
            seg_idx   = SIDX_W'(i);
         end
      end
      tgt_ok_in  = 1'b0;
      tgt_idx_in = sl_idx;
      rs_in      = '0;
      case (op_ff)
         OP_OPEN: begin
            tgt_ok_in  = !dup && free_found;
            tgt_idx_in = free_idx;
            rs_in      = tgt_ok_in ? SLOT_W'(free_idx) : '0;
         end
         OP_SEGMENT: begin
            tgt_ok_in  = seg_found;
            tgt_idx_in = seg_idx;
            rs_in      = seg_found ? SLOT_W'(seg_idx) : '0;
         end
         OP_LISTEN, OP_TICK, OP_CONSUME, OP_CLOSE: begin
            tgt_ok_in = usable;
            rs_in     = slot_ff;
         end
         default: begin
            tgt_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         tgt_ok_ff  <= tgt_ok_in;
         tgt_idx_ff <= tgt_idx_in;
         rs_ff      <= rs_in;
      end
   end

   // apply the operation to the table
   always_comb begin
      in_use_in      = in_use_ff;
      server_port_in = server_port_ff;
      client_port_in = client_port_ff;
      state_in       = state_ff;
      exp_seq_in     = exp_seq_ff;
      used_in        = used_ff;
      cwl_in         = cwl_ff;
      stat_in        = 1'b1;
      have           = 1'b0;
      rv             = 1'b0;
      rtype          = T_NONE;
      st_cur         = state_ff[tgt_idx_ff];
      used_cur       = used_ff[tgt_idx_ff];
      exp_cur        = exp_seq_ff[tgt_idx_ff];
      sum            = (BYTES_W+1)'(len_ff) + (BYTES_W+1)'(used_cur);
      case (op_ff)
         OP_OPEN: begin
            if (tgt_ok_ff) begin
               in_use_in[tgt_idx_ff]      = 1'b1;
               server_port_in[tgt_idx_ff] = open_port_ff;
               client_port_in[tgt_idx_ff] = '0;
               state_in[tgt_idx_ff]       = ST_CLOSED;
               exp_seq_in[tgt_idx_ff]     = '0;
               used_in[tgt_idx_ff]        = '0;
               cwl_in[tgt_idx_ff]         = '0;
               stat_in                    = 1'b0;
               have                       = 1'b1;
            end
         end
         OP_LISTEN: begin
            if (tgt_ok_ff) begin
               state_in[tgt_idx_ff] = ST_LISTENING;
               cwl_in[tgt_idx_ff]   = '0;
               stat_in              = 1'b0;
               have                 = 1'b1;
            end
         end
         OP_SEGMENT: begin
            if (tgt_ok_ff) begin
               stat_in = 1'b0;
               have    = 1'b1;
               case (st_cur)
                  ST_LISTENING: begin
                     if (seg_type_ff == T_SYN) begin
                        client_port_in[tgt_idx_ff] = src_port_ff;
                        exp_seq_in[tgt_idx_ff]     = seq_ff;
                        state_in[tgt_idx_ff]       = ST_CONNECTED;
                        rv                         = 1'b1;
                        rtype                      = T_SYNACK;
                     end
                  end
                  ST_CONNECTED: begin
                     if (seg_type_ff == T_SYN) begin
                        rv    = 1'b1;
                        rtype = T_SYNACK;
                     end else if (seg_type_ff == T_FIN) begin
                        state_in[tgt_idx_ff] = ST_CLOSEWAIT;
                        cwl_in[tgt_idx_ff]   = cw_ticks_ff;
                        rv                   = 1'b1;
                        rtype                = T_FINACK;
                     end else if (seg_type_ff == T_DATA) begin
                        // drop silently on buffer overflow
                        if (sum <= (BYTES_W+1)'(BUF_BYTES)) begin
                           if (seq_ff == exp_cur) begin
                              used_in[tgt_idx_ff]    = sum[BYTES_W-1:0];
                              exp_seq_in[tgt_idx_ff] = exp_cur + SEQ_W'(len_ff);
                           end
                           rv    = 1'b1;
                           rtype = T_DATAACK;
                        end
                     end
                  end
                  ST_CLOSEWAIT: begin
                     if (seg_type_ff == T_FIN) begin
                        rv    = 1'b1;
                        rtype = T_FINACK;
                     end
                  end
                  default: begin
                     rv = 1'b0;
                  end
               endcase
            end
         end
         OP_TICK: begin
            // age every close-wait slot
            for (int i = 0; i < SLOTS; i++) begin
               if (in_use_ff[i] && state_ff[i] == ST_CLOSEWAIT) begin
                  if (cwl_ff[i] <= TICK_W'(1)) begin
                     cwl_in[i]   = '0;
                     state_in[i] = ST_CLOSED;
                     used_in[i]  = '0;
                  end else begin
                     cwl_in[i] = cwl_ff[i] - TICK_W'(1);
                  end
               end
            end
            stat_in = 1'b0;
            have    = tgt_ok_ff;
         end
         OP_CONSUME: begin
            if (tgt_ok_ff) begin
               have = 1'b1;
               if (clen_ff <= used_cur) begin
                  used_in[tgt_idx_ff] = used_cur - clen_ff;
                  stat_in             = 1'b0;
               end
            end
         end
         OP_CLOSE: begin
            if (tgt_ok_ff) begin
               if (st_cur == ST_CLOSED) begin
                  in_use_in[tgt_idx_ff] = 1'b0;
                  used_in[tgt_idx_ff]   = '0;
                  cwl_in[tgt_idx_ff]    = '0;
                  stat_in               = 1'b0;
               end else begin
                  have = 1'b1;
               end
            end
         end
         default: begin
            stat_in = 1'b1;
         end
      endcase
   end

   // write back the table with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            in_use_ff[i]      <= 1'b0;
            client_port_ff[i] <= '0;
            state_ff[i]       <= ST_CLOSED;
            exp_seq_ff[i]     <= '0;
            used_ff[i]        <= '0;
            cwl_ff[i]         <= '0;
         end
      end else if (cmd.exec) begin
         in_use_ff      <= in_use_in;
         client_port_ff <= client_port_in;
         state_ff       <= state_in;
         exp_seq_ff     <= exp_seq_in;
         used_ff        <= used_in;
         cwl_ff         <= cwl_in;
      end
   end

   // server ports are only read for slots in use
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         server_port_ff <= server_port_in;
      end
   end

   // register the result
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         reply_valid_ff <= rv;
         reply_type_ff  <= rv ? rtype : T_NONE;
         reply_src_ff   <= rv ? server_port_in[tgt_idx_ff] : '0;
         reply_dest_ff  <= rv ? client_port_in[tgt_idx_ff] : '0;
         reply_seq_ff   <= (rv && rtype == T_DATAACK) ? '1 : '0;
         reply_ack_ff   <= (rv && rtype == T_DATAACK) ? exp_seq_in[tgt_idx_ff] : '0;
         status_ff      <= stat_in;
         result_slot_ff <= rs_ff;
         slot_state_ff  <= have ? state_in[tgt_idx_ff] : ST_CLOSED;
         slot_used_ff   <= have ? used_in[tgt_idx_ff] : '0;
      end
   end

   assign rsp_reply_valid     = reply_valid_ff;
   assign rsp_reply_type      = reply_type_ff;
   assign rsp_reply_src_port  = reply_src_ff;
   assign rsp_reply_dest_port = reply_dest_ff;
   assign rsp_reply_seq       = reply_seq_ff;
   assign rsp_reply_ack       = reply_ack_ff;
   assign rsp_status          = status_ff;
   assign rsp_result_slot     = result_slot_ff;
   assign rsp_slot_state      = slot_state_ff;
   assign rsp_slot_used_bytes = slot_used_ff;

endmodule

`default_nettype wire
